/* hdl/frontier_cell_detect_assert.svh */
// Assertion macros for the frontier cell detector.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef FRONTIER_CELL_DETECT_ASSERT_SVH
`define FRONTIER_CELL_DETECT_ASSERT_SVH

`ifndef SYNTHESIS

`define FCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("frontier_cell_detect: assertion failed");

`define FCD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("frontier_cell_detect: forbidden condition seen");

`else

`define FCD_ASSERT(lbl, prop)

`define FCD_NEVER(lbl, cond)

`endif

`endif

/* hdl/fcd_pkg.sv */
`timescale 1ns / 1ps

package fcd_pkg;

  localparam int DEF_MAX_WIDTH = 2048;

  localparam int CELL_W      = 8;
  localparam int GRID_W_BITS = 12;
  localparam int GRID_H_BITS = 16;
  localparam int ROW_W       = 17;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam int RESET_GRID_WIDTH  = 2048;
  localparam int RESET_GRID_HEIGHT = 2048;

  localparam logic signed [CELL_W-1:0] CELL_FREE    = 8'sd0;
  localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;

  // Cell class as kept in the line buffers.
  localparam logic [1:0] CLS_OCCUPIED = 2'b00;
  localparam logic [1:0] CLS_FREE     = 2'b01;
  localparam logic [1:0] CLS_UNKNOWN  = 2'b10;

  typedef struct packed {
    logic [1:0] upper;
    logic [1:0] middle;
  } fcd_line_t;

  typedef struct packed {
    logic left;
    logic down;
    logic up;
    logic cunk;
    logic cfree;
  } fcd_win_t;

  typedef struct packed {
    logic frontier;
    logic last;
  } fcd_res_t;

endpackage

/* hdl/frontier_cell_detect.sv */
`timescale 1ns / 1ps

// Channel   Dir  Word                                     Handshake
// s_*       in   tdata[7:0] cell_value, tuser flush        tvalid/tready
// m_*       out  tdata[0] frontier mark, tlast end_of_frame tvalid/tready
// cfg_*     in   cfg_addr register, cfg_wdata value        cfg_we, no wait
//
// One cell per cycle while s_tready is high: each word is classified and the
// stencil evaluated in the cycle it is taken; the result is registered the
// same edge. The row buffer read is prefetched at the next word's column, so the
// line memory port (one write, one registered read per cycle) sets this rate.
// The result for a cell appears width+1 input words after the cell itself.
// A two-entry output stage lets s_tready stay high while one result is stalled.
// Reset is synchronous; it restores the register defaults and clears position,
// window and output state. The line memory is not cleared.

module frontier_cell_detect #(
  parameter int MAX_WIDTH = fcd_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fcd_pkg::CELL_W-1:0]        s_tdata,   // [7:0] cell_value
  input  logic                              s_tuser,   // [0] flush
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [0] frontier mark, [7:1] zero
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [fcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import fcd_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int LW    = $clog2(MAX_WIDTH + 2);
  localparam int RST_W = (RESET_GRID_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_GRID_WIDTH;

  // Configuration, held in effective (clamped) form.
  logic [WW-1:0]          eff_w;
  logic [WW-1:0]          eff_w_next;
  logic [GRID_H_BITS-1:0] eff_h;
  logic [GRID_H_BITS-1:0] eff_h_next;
  logic [GRID_W_BITS-1:0] cfg_gw;

  // Position and stencil state.
  logic [CW-1:0]    column_count;
  logic [CW-1:0]    column_count_next;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] row_count_next;
  logic [LW-1:0]    lag_count;
  logic [LW-1:0]    lag_count_next;
  fcd_win_t         window_cells;
  fcd_win_t         window_cells_next;

  // Line memory: upper and middle rows share one address.
  fcd_line_t        line_mem [MAX_WIDTH];
  fcd_line_t        line_rd;
  fcd_line_t        line_wdata;
  logic             line_we;

  // Output stage.
  logic             out_valid;
  fcd_res_t         out_res;
  logic             skid_valid;
  fcd_res_t         skid_res;

  // Step logic.
  logic                     accept;
  logic signed [CELL_W-1:0] cell_value;
  logic [1:0]               cls;
  logic                     lag_done;
  logic [CW-1:0]            w_m1;
  logic [CW-1:0]            tx;
  logic [ROW_W-1:0]         ty;
  logic [ROW_W:0]           ty_inc;
  logic [CW:0]              cx_inc;
  logic                     border;
  fcd_res_t                 res;
  logic                     res_push;

  assign accept     = s_tvalid && s_tready;
  assign cell_value = s_tdata;
  assign cfg_gw     = cfg_wdata[GRID_W_BITS-1:0];

  always_comb begin
    cls = CLS_OCCUPIED;
    if (!s_tuser && (row_count < {{(ROW_W-GRID_H_BITS){1'b0}}, eff_h})) begin
      if (cell_value == CELL_FREE) begin
        cls = CLS_FREE;
      end else if (cell_value == CELL_UNKNOWN) begin
        cls = CLS_UNKNOWN;
      end
    end
  end

  // The cell being judged is one column back and one row up, or the row end two rows up.
  assign lag_done = lag_count >= (LW'(eff_w) + LW'(1));
  assign w_m1     = CW'(eff_w - WW'(1));
  assign tx       = (column_count != '0) ? (column_count - CW'(1)) : w_m1;
  assign ty       = (column_count != '0) ? (row_count - ROW_W'(1)) : (row_count - ROW_W'(2));
  assign ty_inc   = {1'b0, ty} + (ROW_W+1)'(1);
  assign cx_inc   = {1'b0, column_count} + (CW+1)'(1);

  assign border = (tx == '0) || (tx == w_m1) || (ty == '0) ||
                  (ty_inc >= (ROW_W+1)'(eff_h));

  always_comb begin
    res.frontier = !border && window_cells.cfree &&
                   (window_cells.up || window_cells.down || window_cells.left ||
                    line_rd.middle[1]);
    res.last     = (tx == w_m1) && (ty_inc == (ROW_W+1)'(eff_h));
  end

  assign res_push = accept && lag_done;

  always_comb begin
    eff_w_next        = eff_w;
    eff_h_next        = eff_h;
    column_count_next = column_count;
    row_count_next    = row_count;
    lag_count_next    = lag_count;
    window_cells_next = window_cells;
    line_we           = 1'b0;
    line_wdata.upper  = line_rd.middle;
    line_wdata.middle = cls;

    if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_WIDTH: begin
          if (cfg_gw == '0) begin
            eff_w_next = WW'(1);
          end else if (int'(cfg_gw) > MAX_WIDTH) begin
            eff_w_next = WW'(MAX_WIDTH);
          end else begin
            eff_w_next = WW'(cfg_gw);
          end
        end
        REG_GRID_HEIGHT: begin
          eff_h_next = (cfg_wdata == '0) ? GRID_H_BITS'(1) : cfg_wdata;
        end
        default: begin
        end
      endcase
      column_count_next = '0;
      row_count_next    = '0;
      lag_count_next    = '0;
    end else if (accept) begin
      line_we = 1'b1;
      if (lag_done && res.last) begin
        // Frame done: the window is cleared and the next word starts a frame.
        window_cells_next = '0;
        column_count_next = '0;
        row_count_next    = '0;
        lag_count_next    = '0;
      end else begin
        if (!lag_done) begin
          lag_count_next = lag_count + LW'(1);
        end
        window_cells_next.left  = window_cells.cunk;
        window_cells_next.cfree = line_rd.middle[0];
        window_cells_next.cunk  = line_rd.middle[1];
        window_cells_next.up    = line_rd.upper[1];
        window_cells_next.down  = cls[1];
        if (cx_inc >= (CW+1)'(eff_w)) begin
          column_count_next = '0;
          row_count_next    = row_count + ROW_W'(1);
        end else begin
          column_count_next = cx_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w        <= WW'(RST_W);
      eff_h        <= GRID_H_BITS'(RESET_GRID_HEIGHT);
      column_count <= '0;
      row_count    <= '0;
      lag_count    <= '0;
      window_cells <= '0;
    end else begin
      eff_w        <= eff_w_next;
      eff_h        <= eff_h_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      lag_count    <= lag_count_next;
      window_cells <= window_cells_next;
    end
  end

  // The read is issued at the column the next word will use, so its data is
  // ready when that word arrives. When the next word uses the column being
  // written (one-cell rows, or the restart after a frame end), the written
  // entry is forwarded instead of the stale memory contents.
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[column_count] <= line_wdata;
    end
    if (line_we && (column_count_next == column_count)) begin
      line_rd <= line_wdata;
    end else begin
      line_rd <= line_mem[column_count_next];
    end
  end

  // Output register with one skid entry behind it.
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_res.frontier};
  assign m_tlast  = out_res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid  <= res_push;
        end
      end else if (res_push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_push) begin
      skid_res <= res;
    end
  end

  `include "frontier_cell_detect_assert.svh"

  `FCD_ASSERT(a_skid_behind_out, skid_valid |-> out_valid)
  `FCD_ASSERT(a_column_in_row, (CW+1)'(column_count) < (CW+1)'(eff_w))
  `FCD_ASSERT(a_lag_bounded, lag_count <= (LW'(eff_w) + LW'(1)))
  `FCD_ASSERT(a_frame_restart, (res_push && res.last) |=> (column_count == '0 && lag_count == '0))

endmodule

/* tb/tb_frontier_cell_detect.sv */
`timescale 1ns / 1ps

module tb_frontier_cell_detect;
  import fcd_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int REPORT_CAP    = 100;
  localparam int RANDOM_WORDS  = 500;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [CELL_W-1:0]     s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frontier_cell_detect DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stencil predictor state, mirrors what the block should hold.
  logic [1:0]            upper_classes [MAX_W];
  logic [1:0]            middle_classes [MAX_W];
  fcd_win_t              stencil_win;
  int unsigned           col_pos, row_pos, lag_words;
  logic [GRID_W_BITS-1:0] grid_w_reg;
  logic [GRID_H_BITS-1:0] grid_h_reg;
  fcd_res_t              pending_marks [$];
  fcd_res_t              want_mark;

  int errors, words_sent, marks_checked, frontier_seen, frames_closed, reg_writes;
  int src_stretch, sink_stretch;
  bit src_calm, sink_calm;

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      upper_classes[i] = CLS_OCCUPIED;
      middle_classes[i] = CLS_OCCUPIED;
    end
    stencil_win = '0;
    col_pos = 0;
    row_pos = 0;
    lag_words = 0;
    grid_w_reg = GRID_W_BITS'(RESET_GRID_WIDTH);
    grid_h_reg = GRID_H_BITS'(RESET_GRID_HEIGHT);
  end

  function automatic void advance_stencil(input logic [7:0] value, input logic flush);
    int unsigned w, h, cx, cr, col, tx, ty;
    logic [1:0] cls, above2, above1;
    fcd_win_t prev;
    logic border;
    fcd_res_t res;
    w = (grid_w_reg == 0) ? 1 : ((grid_w_reg > MAX_W) ? MAX_W : grid_w_reg);
    h = (grid_h_reg == 0) ? 1 : grid_h_reg;
    cx = col_pos;
    cr = row_pos;
    col = cx % MAX_W;
    cls = CLS_OCCUPIED;
    if (!flush && cr < h) begin
      if (value == CELL_FREE) cls = CLS_FREE;
      else if (value == CELL_UNKNOWN) cls = CLS_UNKNOWN;
    end
    above2 = upper_classes[col];
    above1 = middle_classes[col];
    upper_classes[col] = above1;
    middle_classes[col] = cls;
    prev = stencil_win;
    res = '0;
    if (lag_words >= w + 1) begin
      // The output cell sits one column left and one row up of the input cell;
      // at column 0 it is the last cell two rows up.
      if (cx >= 1) begin
        tx = cx - 1;
        ty = cr - 1;
      end else begin
        tx = w - 1;
        ty = cr - 2;
      end
      border = (tx == 0) || (tx + 1 >= w) || (ty == 0) || (ty + 1 >= h);
      res.frontier = !border && prev.cfree &&
                     (prev.up || prev.down || prev.left || above1 == CLS_UNKNOWN);
      res.last = (tx + 1 == w) && (ty + 1 == h);
      pending_marks = {pending_marks, res};
    end else begin
      lag_words++;
    end
    if (res.last) begin
      stencil_win = '0;
      col_pos = 0;
      row_pos = 0;
      lag_words = 0;
    end else begin
      stencil_win.left  = prev.cunk;
      stencil_win.cfree = (above1 == CLS_FREE);
      stencil_win.cunk  = (above1 == CLS_UNKNOWN);
      stencil_win.up    = (above2 == CLS_UNKNOWN);
      stencil_win.down  = (cls == CLS_UNKNOWN);
      cx++;
      if (cx >= w) begin
        cx = 0;
        if (cr < 32'h1FFFF) cr++;
      end
      col_pos = cx;
      row_pos = cr;
    end
  endfunction

  // Scoreboard and predictor run off the same edge samples.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_marks.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected result word, expected none, actual tdata=%h tlast=%b",
                     $time, m_tdata, m_tlast);
        end else begin
          want_mark = pending_marks.pop_front();
          marks_checked++;
          if (m_tdata !== {7'b0, want_mark.frontier}) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: frontier mark mismatch, expected tdata=%h actual=%h",
                       $time, {7'b0, want_mark.frontier}, m_tdata);
          end
          if (m_tlast !== want_mark.last) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: end_of_frame mismatch, expected tlast=%b actual=%b",
                       $time, want_mark.last, m_tlast);
          end
          if (want_mark.frontier) frontier_seen++;
          if (want_mark.last) frames_closed++;
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_GRID_WIDTH) grid_w_reg = cfg_wdata[GRID_W_BITS-1:0];
        else if (cfg_addr == REG_GRID_HEIGHT) grid_h_reg = cfg_wdata[GRID_H_BITS-1:0];
        col_pos = 0;
        row_pos = 0;
        lag_words = 0;
      end
      if (s_tvalid && s_tready) advance_stencil(s_tdata, s_tuser);
    end
  end

  // Idle lengths come in stretches, some of which have no idling at all.
  function automatic int draw_wait(inout int stretch, inout bit calm);
    if (stretch == 0) begin
      stretch = $urandom_range(10, 60);
      calm = ($urandom_range(0, 2) == 0);
    end
    stretch--;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  initial begin
    int stall;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = draw_wait(sink_stretch, sink_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d results still pending", $time, pending_marks.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_word(input logic [7:0] value, input logic flush);
    int gap;
    gap = draw_wait(src_stretch, src_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tuser <= flush;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // Waits until the block is idle before touching a register.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_grid(input int w, input int h);
    logic [3:0] junk;
    logic [GRID_W_BITS-1:0] w12;
    junk = 4'($urandom);
    w12 = GRID_W_BITS'(w);
    // Bits above the width register are junk and must be ignored.
    write_reg(REG_GRID_WIDTH, {junk, w12});
    write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic logic [7:0] random_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CELL_FREE;
    if (r < 75) return CELL_UNKNOWN;
    return 8'($urandom);
  endfunction

  // Grid cells first, then drain words; ordinary cells past the frame drain too.
  task automatic send_frame(input int cols, input int rows, input int total);
    for (int k = 0; k < total; k++) begin
      if (k < cols * rows)
        send_word(random_cell(), $urandom_range(0, 99) < 3);
      else
        send_word(random_cell(), $urandom_range(0, 99) < 60);
    end
  endtask

  task automatic test_reset_defaults();
    // Full size grid after reset: words are taken but nothing comes out yet.
    send_word(CELL_FREE, 1'b0);
    send_word(CELL_UNKNOWN, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(CELL_UNKNOWN, 1'b1);
    send_word(CELL_FREE, 1'b1);
  endtask

  task automatic test_neighbour_rules();
    logic [7:0] layout [20];
    layout = '{CELL_FREE, CELL_UNKNOWN, CELL_FREE, CELL_FREE, 8'd127,
               CELL_FREE, CELL_FREE, CELL_FREE, CELL_FREE, CELL_FREE,
               CELL_FREE, CELL_FREE, CELL_UNKNOWN, CELL_FREE, CELL_FREE,
               8'h80, CELL_FREE, CELL_FREE, CELL_FREE, CELL_FREE};
    // 5x4 grid: interior cells hit the up, down, left and right rules one each.
    write_grid(5, 4);
    for (int k = 0; k < 20; k++) send_word(layout[k], k == 8);
    send_word(CELL_FREE, 1'b1);
    send_word(CELL_UNKNOWN, 1'b0);
    send_word(CELL_UNKNOWN, 1'b1);
    send_word(CELL_FREE, 1'b0);
    send_word(8'h2A, 1'b0);
    send_word(CELL_FREE, 1'b1);
  endtask

  task automatic test_odd_registers();
    write_grid(0, 3);
    send_frame(1, 3, 5);
    write_grid(4, 0);
    send_frame(4, 1, 9);
    write_grid(2, 5);
    send_frame(2, 5, 13);
  endtask

  task automatic test_widest_rows();
    // A width above the line buffer size clamps to the buffer size, so a short
    // run of words stays inside the lag and yields no result.
    write_grid(4095, 3);
    send_frame(MAX_W, 3, 60);
  endtask

  task automatic test_tallest_grid();
    write_grid(6, 65535);
    send_frame(6, 65535, 200);
  endtask

  task automatic test_random_frames();
    int start, w, h, ew, eh, total, r;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      r = $urandom_range(0, 9);
      if (r < 7) w = $urandom_range(3, 10);
      else if (r == 7) w = $urandom_range(1, 2);
      else if (r == 8) w = $urandom_range(11, 24);
      else w = 0;
      r = $urandom_range(0, 9);
      if (r < 7) h = $urandom_range(3, 8);
      else if (r == 7) h = $urandom_range(1, 2);
      else if (r == 8) h = 0;
      else h = $urandom_range(9, 12);
      write_grid(w, h);
      ew = (w == 0) ? 1 : w;
      eh = (h == 0) ? 1 : h;
      for (int f = $urandom_range(1, 3); f > 0 && words_sent - start < RANDOM_WORDS; f--) begin
        total = ew * eh + ew + 1;
        r = $urandom_range(0, 7);
        // Now and then a frame is cut short or followed by stray words.
        if (r == 0) total = $urandom_range(1, total - 1);
        else if (r == 1) total += $urandom_range(1, 3);
        send_frame(ew, eh, total);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_GRID_WIDTH;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_neighbour_rules();
    test_odd_registers();
    test_widest_rows();
    test_tallest_grid();
    test_random_frames();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    $display("Sent %0d cell words over %0d register writes: reset sizes, zero and clamped",
             words_sent, reg_writes);
    $display("registers, a tall grid and random frames with cut and padded endings.");
    $display("Compared %0d results: %0d frontier marks, %0d frames closed, %0d mismatches.",
             marks_checked, frontier_seen, frames_closed, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
